/* hdl/vtc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtc_pkg
// Shared types and constants for the virtual IP traffic counter.
// ----------------------------------------------------------------------------
package vtc_pkg;
    localparam int VIP_ENTRIES = 64;
    localparam int SLOT_W      = 6;
    localparam int IDX_W       = (VIP_ENTRIES > 1) ? $clog2(VIP_ENTRIES) : 1;

    localparam logic [1:0] FUNC_BYTE  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [1:0] KIND_VERDICT = 2'd0;
    localparam logic [1:0] KIND_READ    = 2'd1;
    localparam logic [1:0] KIND_ACK     = 2'd2;

    localparam logic [15:0] ETH_IPV4   = 16'h0800;
    localparam logic [15:0] ETH_IPV6   = 16'h86DD;
    localparam logic [16:0] MIN_LEN_V4 = 17'd34;
    localparam logic [16:0] MIN_LEN_V6 = 17'd54;

    // controller -> datapath
    typedef struct packed {
        logic take_byte;   // capture the input word as a frame byte
        logic do_write;    // write table entry
        logic scan_start;  // clear search state, begin scan
        logic scan_step;   // test entry at scan index
        logic upd_rd;      // read counters of selected entry
        logic upd_wr;      // write back updated counters
        logic rd_req;      // readback read
        logic emit;        // drive result
        logic emit_kind_v; // result is a verdict
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic frame_ok;
        logic scan_done;
        logic hit;
    } t_sts;
endpackage
`default_nettype wire

/* hdl/vtc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtc_ctrl
// Sequencer: byte capture, table scan, counter update and result timing.
// ----------------------------------------------------------------------------
module vtc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [1:0]    i_func,
    input  wire logic          i_last_byte,
    input  wire vtc_pkg::t_sts i_sts,
    output vtc_pkg::t_cmd      o_cmd,
    output logic               o_busy
);
    import vtc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CHK  = 7'b0000010,
        S_SCAN = 7'b0000100,
        S_URD  = 7'b0001000,
        S_UWR  = 7'b0010000,
        S_OUT  = 7'b0100000,
        S_RD   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    wire logic acc = i_start && r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (i_func)
                        FUNC_BYTE: begin
                            o_cmd.take_byte = 1'b1;
                            if (i_last_byte) n_state = S_CHK;
                        end
                        FUNC_WRITE: begin
                            o_cmd.do_write = 1'b1;
                            o_cmd.emit     = 1'b1;
                        end
                        FUNC_READ: begin
                            o_cmd.rd_req = 1'b1;
                            n_state      = S_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_CHK: begin
                o_cmd.scan_start = 1'b1;
                n_state = i_sts.frame_ok ? S_SCAN : S_OUT;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.hit)            n_state = S_URD;
                else if (i_sts.scan_done) n_state = S_OUT;
            end
            S_URD: begin
                o_cmd.upd_rd = 1'b1;
                n_state = S_UWR;
            end
            S_UWR: begin
                o_cmd.upd_wr = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_cmd.emit        = 1'b1;
                o_cmd.emit_kind_v = 1'b1;
                n_state = S_IDLE;
            end
            S_RD: begin
                o_cmd.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = r_state != S_IDLE;
endmodule
`default_nettype wire

/* hdl/vtc_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtc_dp
// Datapath: header capture, entry table, counter memory and result register.
// ----------------------------------------------------------------------------
module vtc_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire vtc_pkg::t_cmd i_cmd,
    input  wire logic          i_direction,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic [5:0]    i_slot,
    input  wire logic [63:0]   i_addr_high,
    input  wire logic [63:0]   i_addr_low,
    input  wire logic          i_is_ipv6,
    input  wire logic          i_entry_valid,
    output vtc_pkg::t_sts      o_sts,
    output logic               o_valid,
    output logic [1:0]         o_kind,
    output logic               o_matched,
    output logic [5:0]         o_hit_slot,
    output logic [63:0]        o_packet_count,
    output logic [63:0]        o_byte_count
);
    import vtc_pkg::*;

    logic [15:0] r_pos;
    logic [15:0] r_etype;
    logic [63:0] r_cap_hi, r_cap_lo;
    logic        r_dir;
    logic [16:0] r_len;

    logic [VIP_ENTRIES-1:0] r_vbit;
    logic        r_fam   [VIP_ENTRIES];
    logic [63:0] r_ahi   [VIP_ENTRIES];
    logic [63:0] r_alo   [VIP_ENTRIES];
    // counters: packet/byte per direction; entry epoch via clear bits
    logic [63:0] r_pkt   [2*VIP_ENTRIES];
    logic [63:0] r_byt   [2*VIP_ENTRIES];
    logic [2*VIP_ENTRIES-1:0] r_cnt_ok; // counter pair holds written data

    logic [IDX_W:0]   r_scan;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_hit;
    logic [63:0]      r_ent_hi, r_ent_lo;
    logic             r_ent_fam, r_ent_v;
    logic [63:0]      r_cp, r_cb;
    logic             r_cok;

    // header capture
    logic [4:0]  v4s;
    logic [5:0]  v6s;
    logic [15:0] et_n;
    always_comb begin
        v4s  = i_direction ? 5'd26 : 5'd30;
        v6s  = i_direction ? 6'd22 : 6'd38;
        et_n = r_etype;
        if (r_pos == 16'd12)      et_n = {i_data_byte, r_etype[7:0]};
        else if (r_pos == 16'd13) et_n = {r_etype[15:8], i_data_byte};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit_kind_v) begin
            r_pos <= '0; r_etype <= '0; r_cap_hi <= '0; r_cap_lo <= '0;
        end else if (i_cmd.take_byte) begin
            r_dir   <= i_direction;
            r_len   <= {1'b0, r_pos} + 17'd1;
            r_etype <= et_n;
            if (r_pos != 16'hFFFF) r_pos <= r_pos + 16'd1;
            if (et_n == ETH_IPV4 && r_pos >= {11'd0, v4s} && r_pos < {11'd0, v4s} + 16'd4) begin
                r_cap_lo <= {32'd0, r_cap_lo[23:0], i_data_byte};
                r_cap_hi <= '0;
            end else if (et_n == ETH_IPV6 && r_pos >= {10'd0, v6s}
                         && r_pos < {10'd0, v6s} + 16'd16) begin
                if (r_pos < {10'd0, v6s} + 16'd8) r_cap_hi <= {r_cap_hi[55:0], i_data_byte};
                else                             r_cap_lo <= {r_cap_lo[55:0], i_data_byte};
            end
        end
    end

    wire logic v6f = r_etype == ETH_IPV6;
    assign o_sts.frame_ok = (r_etype == ETH_IPV4 && r_len >= MIN_LEN_V4) ||
                            (v6f && r_len >= MIN_LEN_V6);

    wire logic slot_in = {1'b0, i_slot} < 7'(VIP_ENTRIES);
    wire logic [IDX_W-1:0] sidx = IDX_W'(i_slot);

    // entry table: one entry read per cycle during scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vbit <= '0;
        else if (i_cmd.do_write && slot_in) r_vbit[sidx] <= i_entry_valid;
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_write && slot_in) begin
            r_fam[sidx] <= i_is_ipv6;
            r_ahi[sidx] <= i_is_ipv6 ? i_addr_high : 64'd0;
            r_alo[sidx] <= i_is_ipv6 ? i_addr_low : {32'd0, i_addr_low[31:0]};
        end
    end

    // scan: read entry at r_scan (registered), compare next cycle
    wire logic [IDX_W-1:0] scan_idx = r_scan[IDX_W-1:0];
    logic r_cmp_ok; // registered entry data is valid to compare
    logic [IDX_W-1:0] r_cmp_idx;
    always_ff @(posedge i_clk) begin
        r_ent_hi  <= r_ahi[scan_idx];
        r_ent_lo  <= r_alo[scan_idx];
        r_ent_fam <= r_fam[scan_idx];
        r_ent_v   <= r_vbit[scan_idx];
        r_cmp_idx <= scan_idx;
    end

    wire logic cmp_hit = r_cmp_ok && r_ent_v && (r_ent_fam == v6f) &&
                         r_ent_hi == r_cap_hi && r_ent_lo == r_cap_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0; r_cmp_ok <= 1'b0; r_hit <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_scan <= '0; r_cmp_ok <= 1'b0; r_hit <= 1'b0;
        end else if (i_cmd.scan_step) begin
            if (r_scan < (IDX_W+1)'(VIP_ENTRIES)) r_scan <= r_scan + (IDX_W+1)'(1);
            r_cmp_ok <= r_scan < (IDX_W+1)'(VIP_ENTRIES);
            if (cmp_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_cmp_idx;
            end
        end else if (i_cmd.emit_kind_v) begin
            r_hit <= 1'b0;
        end
    end
    assign o_sts.hit       = i_cmd.scan_step && cmp_hit;
    assign o_sts.scan_done = r_scan == (IDX_W+1)'(VIP_ENTRIES) && !r_cmp_ok;

    // counter memory
    wire logic [IDX_W:0] upd_a = {r_hit_idx, r_dir};
    wire logic [IDX_W:0] rd_a  = {sidx, i_direction};
    wire logic [IDX_W:0] ca    = i_cmd.rd_req ? rd_a : upd_a;
    logic        r_rd_in;
    logic [5:0]  r_rd_slot;
    always_ff @(posedge i_clk) begin
        r_cp <= r_pkt[ca];
        r_cb <= r_byt[ca];
        if (i_cmd.upd_wr) begin
            r_pkt[upd_a] <= (r_cok ? r_cp : 64'd0) + 64'd1;
            r_byt[upd_a] <= (r_cok ? r_cb : 64'd0) + {47'd0, r_len};
        end
        if (i_cmd.rd_req) begin
            r_rd_in   <= slot_in;
            r_rd_slot <= i_slot;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cok <= 1'b0;
        else if (i_cmd.upd_rd || i_cmd.rd_req) r_cok <= r_cnt_ok[ca];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cnt_ok <= '0;
        else if (i_cmd.do_write && slot_in) begin
            r_cnt_ok[{sidx, 1'b0}] <= 1'b0;
            r_cnt_ok[{sidx, 1'b1}] <= 1'b0;
        end else if (i_cmd.upd_wr) r_cnt_ok[upd_a] <= 1'b1;
    end

    // result register
    logic [63:0] r_np, r_nb;
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd_wr) begin
            r_np <= (r_cok ? r_cp : 64'd0) + 64'd1;
            r_nb <= (r_cok ? r_cb : 64'd0) + {47'd0, r_len};
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= i_cmd.emit;
        if (i_cmd.emit) begin
            o_matched <= 1'b0; o_packet_count <= '0; o_byte_count <= '0;
            if (i_cmd.emit_kind_v) begin
                o_kind <= KIND_VERDICT;
                o_hit_slot <= '0;
                if (r_hit) begin
                    o_matched <= 1'b1;
                    o_hit_slot <= 6'(r_hit_idx);
                    o_packet_count <= r_np;
                    o_byte_count <= r_nb;
                end
            end else if (i_cmd.do_write) begin
                o_kind <= KIND_ACK;
                o_hit_slot <= i_slot;
            end else begin
                o_kind <= KIND_READ;
                o_hit_slot <= r_rd_slot;
                if (r_rd_in && r_cok) begin
                    o_packet_count <= r_cp;
                    o_byte_count <= r_cb;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* hdl/vip_traffic_counter_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Frame byte words: accepted back to back; busy stays low except after a last byte or a read.
// Last byte: the table is scanned one entry per cycle, then counters are updated on a hit and the verdict is sent.
// Write: acknowledged the cycle after start; read: via the counter memory port, result driven from S_RD.
// Results come as a one-cycle strobe on o_valid; the receiver cannot stall.
// Synchronous active-low reset clears valid bits and frame state; no clearing pass.
// ----------------------------------------------------------------------------
// vip_traffic_counter_top
// Per virtual IP packet and byte counter over a byte stream of frames.
// ----------------------------------------------------------------------------
module vip_traffic_counter_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_func,
    input  wire logic        i_direction,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    input  wire logic [5:0]  i_slot,
    input  wire logic [63:0] i_addr_high,
    input  wire logic [63:0] i_addr_low,
    input  wire logic        i_is_ipv6,
    input  wire logic        i_entry_valid,
    output logic             o_valid,
    output logic [1:0]       o_kind,
    output logic             o_matched,
    output logic [5:0]       o_hit_slot,
    output logic [63:0]      o_packet_count,
    output logic [63:0]      o_byte_count
);
    import vtc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    vtc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_func(i_func),
        .i_last_byte(i_last_byte), .i_sts(sts), .o_cmd(cmd), .o_busy(busy)
    );

    vtc_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_direction(i_direction), .i_data_byte(i_data_byte), .i_slot(i_slot),
        .i_addr_high(i_addr_high), .i_addr_low(i_addr_low), .i_is_ipv6(i_is_ipv6),
        .i_entry_valid(i_entry_valid), .o_sts(sts), .o_valid(o_valid),
        .o_kind(o_kind), .o_matched(o_matched), .o_hit_slot(o_hit_slot),
        .o_packet_count(o_packet_count), .o_byte_count(o_byte_count)
    );

`ifndef NO_ASSERTIONS
    a_match_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_matched |-> o_kind == KIND_VERDICT) else $error("match on non-verdict");
    a_ack_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_func == FUNC_WRITE |=> o_valid && o_kind == KIND_ACK)
        else $error("write not acknowledged");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.take_byte, cmd.do_write, cmd.scan_step, cmd.upd_rd, cmd.upd_wr}))
        else $error("conflicting datapath commands");
`endif
endmodule
`default_nettype wire
